[sv/atrlc_pkg.sv]
// Shared types, constants and pattern tables for the AT response line classifier.
`default_nettype none

package atrlc_pkg;

    localparam int unsigned NUM_PATTERNS = 4;
    localparam logic [3:0]  PREFIX_LEN   = 4'd11;

    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_PROMPT = 8'h3E;
    localparam logic [7:0] BYTE_SPACE  = 8'h20;
    localparam logic [7:0] BYTE_TAB    = 8'h09;

    localparam logic [1:0] PAT_OK  = 2'd0;
    localparam logic [1:0] PAT_ERR = 2'd1;
    localparam logic [1:0] PAT_CME = 2'd2;
    localparam logic [1:0] PAT_CMS = 2'd3;

    localparam logic [2:0] CLASS_OTHER = 3'd0;
    localparam logic [2:0] CLASS_OK    = 3'd1;
    localparam logic [2:0] CLASS_ERROR = 3'd2;
    localparam logic [2:0] CLASS_CME   = 3'd3;
    localparam logic [2:0] CLASS_CMS   = 3'd4;

    typedef struct packed {
        logic [3:0] candidate_alive;
        logic [3:0] match_position;
        logic       visible_seen;
    } matcher_t;

    localparam matcher_t MATCHER_CLEAR = '{candidate_alive: 4'hF,
                                           match_position:  4'd0,
                                           visible_seen:    1'b0};

    typedef struct packed {
        logic       line_done;
        logic [2:0] line_class;
        logic       in_response;
        logic       response_done;
        logic       prompt_consumed;
        logic       prompt_event;
    } result_t;

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == BYTE_SPACE) || (b == BYTE_TAB);
    endfunction

    function automatic logic [3:0] pattern_len(input logic [1:0] idx);
        unique case (idx)
            PAT_OK:  pattern_len = 4'd2;
            PAT_ERR: pattern_len = 4'd5;
            default: pattern_len = PREFIX_LEN;
        endcase
    endfunction

    // OK and ERROR must stand alone on the line; the error prefixes may be followed by text
    function automatic logic pattern_whole(input logic [1:0] idx);
        pattern_whole = (idx == PAT_OK) || (idx == PAT_ERR);
    endfunction

    function automatic logic [7:0] pattern_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            PAT_OK:
            begin
                case (pos)
                    4'd0:    ch = "O";
                    4'd1:    ch = "K";
                    default: ch = 8'h00;
                endcase
            end
            PAT_ERR:
            begin
                case (pos)
                    4'd0:    ch = "E";
                    4'd1:    ch = "R";
                    4'd2:    ch = "R";
                    4'd3:    ch = "O";
                    4'd4:    ch = "R";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    4'd0:    ch = "+";
                    4'd1:    ch = "C";
                    4'd2:    ch = "M";
                    4'd3:    ch = (idx == PAT_CME) ? "E" : "S";
                    4'd4:    ch = " ";
                    4'd5:    ch = "E";
                    4'd6:    ch = "R";
                    4'd7:    ch = "R";
                    4'd8:    ch = "O";
                    4'd9:    ch = "R";
                    4'd10:   ch = ":";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        pattern_char = ch;
    endfunction

    function automatic logic [2:0] class_of(input matcher_t m);
        logic [2:0] cls;
        cls = CLASS_OTHER;
        if (m.candidate_alive[PAT_OK] && m.match_position >= pattern_len(PAT_OK))
            cls = CLASS_OK;
        else if (m.candidate_alive[PAT_ERR] && m.match_position >= pattern_len(PAT_ERR))
            cls = CLASS_ERROR;
        else if (m.candidate_alive[PAT_CME] && m.match_position >= pattern_len(PAT_CME))
            cls = CLASS_CME;
        else if (m.candidate_alive[PAT_CMS] && m.match_position >= pattern_len(PAT_CMS))
            cls = CLASS_CMS;
        class_of = cls;
    endfunction

endpackage

`default_nettype wire

[sv/at_response_line_classifier_top.sv]
// AT response line classifier: byte-wise line splitter, trimmer and status matcher.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid, in_stall | action, rx_byte, command_active, prompt_wanted
//  out     | out_valid,out_stall| line_done, line_class, in_response,
//          |                    | response_done, prompt_consumed, prompt_event
//
// One transaction per cycle in and out while neither side stalls; each result is registered.
// The matcher update is combinational from the input and the line state registers.
// A result register plus a one-entry skid buffer decouple the two sides; in_stall
// rises only when both hold a result, and comes from a register.
// rst_n clears the line state and empties both result entries.
`default_nettype none

module at_response_line_classifier_top (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   action,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   command_active,
    input  wire logic                   prompt_wanted,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        line_done,
    output logic [2:0]                  line_class,
    output logic                        in_response,
    output logic                        response_done,
    output logic                        prompt_consumed,
    output logic                        prompt_event
);
    import atrlc_pkg::*;

    logic     partial_nonempty_reg, partial_nonempty_next;
    logic     last_was_cr_reg, last_was_cr_next;
    logic     before_last_was_cr_reg, before_last_was_cr_next;
    matcher_t matcher_reg, matcher_next;
    matcher_t snap0_reg, snap0_next;
    matcher_t snap1_reg, snap1_next;
    matcher_t matcher_fed;
    matcher_t snap_sel;
    result_t  res_next;

    logic     out_valid_reg;
    logic     skid_valid_reg;
    result_t  out_data_reg;
    result_t  skid_data_reg;

    logic     in_accept;
    logic     out_free;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        matcher_fed = matcher_reg;
        if (matcher_reg.visible_seen || !is_blank(rx_byte))
        begin
            matcher_fed.visible_seen = 1'b1;
            for (int c = 0; c < NUM_PATTERNS; c++)
            begin
                if (matcher_reg.match_position < pattern_len(2'(c)))
                begin
                    if (rx_byte != pattern_char(2'(c), matcher_reg.match_position))
                        matcher_fed.candidate_alive[c] = 1'b0;
                end
                else if (pattern_whole(2'(c)) && !is_blank(rx_byte))
                begin
                    matcher_fed.candidate_alive[c] = 1'b0;
                end
            end
            if (matcher_reg.match_position < PREFIX_LEN)
                matcher_fed.match_position = matcher_reg.match_position + 4'd1;
        end
    end

    // CR CR LF endings look two bytes back so neither CR reaches the match
    assign snap_sel = before_last_was_cr_reg ? snap1_reg : snap0_reg;

    always_comb
    begin
        res_next                = '0;
        partial_nonempty_next   = partial_nonempty_reg;
        last_was_cr_next        = last_was_cr_reg;
        before_last_was_cr_next = before_last_was_cr_reg;
        matcher_next            = matcher_reg;
        snap0_next              = snap0_reg;
        snap1_next              = snap1_reg;
        if (action || (rx_byte == BYTE_LF && last_was_cr_reg))
        begin
            if (!action && snap_sel.visible_seen)
            begin
                res_next.line_done     = 1'b1;
                res_next.line_class    = class_of(snap_sel);
                res_next.in_response   = command_active;
                res_next.response_done = command_active && (class_of(snap_sel) != CLASS_OTHER);
            end
            partial_nonempty_next   = 1'b0;
            last_was_cr_next        = 1'b0;
            before_last_was_cr_next = 1'b0;
            matcher_next            = MATCHER_CLEAR;
            snap0_next              = MATCHER_CLEAR;
            snap1_next              = MATCHER_CLEAR;
        end
        else if (!partial_nonempty_reg && rx_byte == BYTE_PROMPT)
        begin
            res_next.prompt_consumed = 1'b1;
            res_next.prompt_event    = prompt_wanted;
        end
        else
        begin
            snap1_next              = snap0_reg;
            snap0_next              = matcher_reg;
            matcher_next            = matcher_fed;
            before_last_was_cr_next = last_was_cr_reg;
            last_was_cr_next        = (rx_byte == BYTE_CR);
            partial_nonempty_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_nonempty_reg   <= 1'b0;
            last_was_cr_reg        <= 1'b0;
            before_last_was_cr_reg <= 1'b0;
            matcher_reg            <= MATCHER_CLEAR;
            snap0_reg              <= MATCHER_CLEAR;
            snap1_reg              <= MATCHER_CLEAR;
        end
        else if (in_accept)
        begin
            partial_nonempty_reg   <= partial_nonempty_next;
            last_was_cr_reg        <= last_was_cr_next;
            before_last_was_cr_reg <= before_last_was_cr_next;
            matcher_reg            <= matcher_next;
            snap0_reg              <= snap0_next;
            snap1_reg              <= snap1_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_accept)
                out_data_reg <= res_next;
        end
        else if (in_accept)
        begin
            skid_data_reg <= res_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign line_done       = out_data_reg.line_done;
    assign line_class      = out_data_reg.line_class;
    assign in_response     = out_data_reg.in_response;
    assign response_done   = out_data_reg.response_done;
    assign prompt_consumed = out_data_reg.prompt_consumed;
    assign prompt_event    = out_data_reg.prompt_event;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty result register");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        matcher_reg.match_position <= PREFIX_LEN)
        else $error("match position beyond prefix length");

    a_pos_needs_visible: assert property (@(posedge clk) disable iff (!rst_n)
        !matcher_reg.visible_seen |-> matcher_reg.match_position == 4'd0)
        else $error("match position moved before a visible byte");

    a_line_or_prompt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.line_done && out_data_reg.prompt_consumed))
        else $error("line end and prompt in one transaction");

    a_done_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.response_done |->
            out_data_reg.line_done && out_data_reg.in_response)
        else $error("response done without a finished response line");

endmodule

`default_nettype wire

[dv/at_response_line_classifier_checker.sv]
// Checker for the AT response line classifier: predicts each result and compares it.
`timescale 1ns / 1ps

module at_response_line_classifier_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic       action,
    input  wire logic [7:0] rx_byte,
    input  wire logic       command_active,
    input  wire logic       prompt_wanted,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       line_done,
    input  wire logic [2:0] line_class,
    input  wire logic       in_response,
    input  wire logic       response_done,
    input  wire logic       prompt_consumed,
    input  wire logic       prompt_event,
    output int              fail_count,
    output int              pending
);
    import atrlc_pkg::*;

    localparam int PRINT_CAP = 40;

    result_t  expected_results[$];
    int       mismatches = 0;
    int       outstanding = 0;
    int       results_seen = 0;

    // line state of the predictor
    logic     line_open = 1'b0;
    logic     last_cr = 1'b0;
    logic     prev_cr = 1'b0;
    matcher_t live_match = MATCHER_CLEAR;
    matcher_t snap_last = MATCHER_CLEAR;
    matcher_t snap_prior = MATCHER_CLEAR;

    assign fail_count = mismatches;
    assign pending = outstanding;

    function automatic logic [87:0] status_text(input logic [1:0] idx);
        case (idx)
            PAT_OK:  status_text = "OK";
            PAT_ERR: status_text = "ERROR";
            PAT_CME: status_text = "+CME ERROR:";
            default: status_text = "+CMS ERROR:";
        endcase
    endfunction

    function automatic logic [3:0] status_len(input logic [1:0] idx);
        case (idx)
            PAT_OK:  status_len = 4'd2;
            PAT_ERR: status_len = 4'd5;
            default: status_len = PREFIX_LEN;
        endcase
    endfunction

    function automatic logic [2:0] line_status(input matcher_t m);
        logic [2:0] cls;
        cls = CLASS_OTHER;
        if (m.candidate_alive[PAT_CMS] && m.match_position >= status_len(PAT_CMS))
            cls = CLASS_CMS;
        if (m.candidate_alive[PAT_CME] && m.match_position >= status_len(PAT_CME))
            cls = CLASS_CME;
        if (m.candidate_alive[PAT_ERR] && m.match_position >= status_len(PAT_ERR))
            cls = CLASS_ERROR;
        if (m.candidate_alive[PAT_OK] && m.match_position >= status_len(PAT_OK))
            cls = CLASS_OK;
        return cls;
    endfunction

    task automatic clear_line();
        line_open = 1'b0;
        last_cr = 1'b0;
        prev_cr = 1'b0;
        live_match = MATCHER_CLEAR;
        snap_last = MATCHER_CLEAR;
        snap_prior = MATCHER_CLEAR;
    endtask

    task automatic match_byte(input logic [7:0] b);
        logic       blank;
        logic [3:0] pos;
        logic [3:0] len;
        logic [87:0] txt;
        logic [1:0] idx;
        int         sh;
        blank = (b == BYTE_SPACE) || (b == BYTE_TAB);
        if (!live_match.visible_seen && blank)
            return;
        live_match.visible_seen = 1'b1;
        pos = live_match.match_position;
        for (int c = 0; c < NUM_PATTERNS; c++)
        begin
            idx = 2'(c);
            len = status_len(idx);
            txt = status_text(idx);
            if (live_match.candidate_alive[c])
            begin
                if (pos < len)
                begin
                    sh = (int'(len) - 1 - int'(pos)) * 8;
                    if (b != txt[sh +: 8])
                        live_match.candidate_alive[c] = 1'b0;
                end
                else if ((idx == PAT_OK || idx == PAT_ERR) && !blank)
                    live_match.candidate_alive[c] = 1'b0;
            end
        end
        if (pos < PREFIX_LEN)
            live_match.match_position = pos + 4'd1;
    endtask

    task automatic classify_byte(input logic drop, input logic [7:0] b, input logic cmd,
                                 input logic want, output result_t r);
        matcher_t   snap;
        logic [2:0] cls;
        r = '0;
        if (drop)
        begin
            clear_line();
            return;
        end
        if (b == BYTE_LF && last_cr)
        begin
            snap = prev_cr ? snap_prior : snap_last;
            if (snap.visible_seen)
            begin
                cls = line_status(snap);
                r.line_done = 1'b1;
                r.line_class = cls;
                r.in_response = cmd;
                r.response_done = cmd && (cls != CLASS_OTHER);
            end
            clear_line();
            return;
        end
        if (!line_open && b == BYTE_PROMPT)
        begin
            r.prompt_consumed = 1'b1;
            r.prompt_event = want;
            return;
        end
        snap_prior = snap_last;
        snap_last = live_match;
        match_byte(b);
        prev_cr = last_cr;
        last_cr = (b == BYTE_CR);
        line_open = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s at result %0d: got %0d, expected %0d",
                     $realtime, what, results_seen, got, exp_v);
        mismatches++;
    endtask

    task automatic compare_result(input result_t exp_r, input result_t got_r);
        if (got_r.line_done !== exp_r.line_done)
            report_mismatch("line_done", got_r.line_done, exp_r.line_done);
        if (got_r.line_class !== exp_r.line_class)
            report_mismatch("line_class", got_r.line_class, exp_r.line_class);
        if (got_r.in_response !== exp_r.in_response)
            report_mismatch("in_response", got_r.in_response, exp_r.in_response);
        if (got_r.response_done !== exp_r.response_done)
            report_mismatch("response_done", got_r.response_done, exp_r.response_done);
        if (got_r.prompt_consumed !== exp_r.prompt_consumed)
            report_mismatch("prompt_consumed", got_r.prompt_consumed, exp_r.prompt_consumed);
        if (got_r.prompt_event !== exp_r.prompt_event)
            report_mismatch("prompt_event", got_r.prompt_event, exp_r.prompt_event);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t exp_r;
        result_t got_r;
        if (!rst_n)
        begin
            clear_line();
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_r.line_done = line_done;
                got_r.line_class = line_class;
                got_r.in_response = in_response;
                got_r.response_done = response_done;
                got_r.prompt_consumed = prompt_consumed;
                got_r.prompt_event = prompt_event;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected transaction", 1, 0);
                else
                begin
                    exp_r = expected_results.pop_front();
                    compare_result(exp_r, got_r);
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                classify_byte(action, rx_byte, command_active, prompt_wanted, exp_r);
                expected_results.push_back(exp_r);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

[dv/at_response_line_classifier_top_tb.sv]
// Testbench top for the AT response line classifier: stimulus, idling and verdict.
`timescale 1ns / 1ps

module at_response_line_classifier_top_tb;
    import atrlc_pkg::*;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_DROP = 1'b1;
    localparam int   PHASE_ITEMS = 310;
    localparam int   HOLD_CYCLES = 200;
    localparam int   CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic       action;
        logic [7:0] rx;
        logic       cmd;
        logic       want;
    } rx_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       action = 1'b0;
    logic [7:0] rx_byte = 8'h00;
    logic       command_active = 1'b0;
    logic       prompt_wanted = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       line_done;
    logic [2:0] line_class;
    logic       in_response;
    logic       response_done;
    logic       prompt_consumed;
    logic       prompt_event;
    int         fail_count;
    int         pending;

    rx_item_t   rx_queue[$];
    logic       line_cmd = 1'b0;
    logic       line_want = 1'b0;
    int         in_idle_pct = 0;
    int         out_stall_pct = 0;
    logic       hold_go = 1'b0;
    int         held_cycles = 0;
    int         cycles = 0;

    at_response_line_classifier_top DUT (.*);

    at_response_line_classifier_checker result_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("at_response_line_classifier_top regression: fail");
            $finish;
        end
    end

    // receiver: one long hold-off when asked, random stalls otherwise
    always @(posedge clk)
    begin
        if (hold_go && held_cycles < HOLD_CYCLES)
        begin
            held_cycles <= held_cycles + 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    task automatic add_item(input logic act, input logic [7:0] b);
        rx_item_t s;
        s.action = act;
        s.rx = b;
        s.cmd = ($urandom_range(0, 15) == 0) ? 1'($urandom_range(0, 1)) : line_cmd;
        s.want = ($urandom_range(0, 15) == 0) ? 1'($urandom_range(0, 1)) : line_want;
        rx_queue.push_back(s);
    endtask

    task automatic add_text(input string t);
        for (int i = 0; i < t.len(); i++)
            add_item(ACT_BYTE, t[i]);
    endtask

    task automatic add_blanks(input int n);
        for (int i = 0; i < n; i++)
            add_item(ACT_BYTE, $urandom_range(0, 1) ? BYTE_SPACE : BYTE_TAB);
    endtask

    task automatic add_crlf(input int extra_cr);
        for (int i = 0; i <= extra_cr; i++)
            add_item(ACT_BYTE, BYTE_CR);
        add_item(ACT_BYTE, BYTE_LF);
    endtask

    task automatic add_line_end();
        int r;
        r = $urandom_range(0, 9);
        add_crlf(r < 6 ? 0 : (r < 9 ? 1 : 2));
    endtask

    function automatic string line_body();
        string s;
        int    n;
        case ($urandom_range(0, 15))
            0, 1:    s = "OK";
            2, 3:    s = "ERROR";
            4:       s = $sformatf("+CME ERROR: %0d", $urandom_range(0, 999));
            5:       s = $sformatf("+CMS ERROR:%0d", $urandom_range(0, 999));
            6:       s = "+CME ERROR:";
            7:       s = "+CMS ERROR:";
            8:       s = "OKAY";
            9:       s = "OK\tOK";
            10:      s = "ERRO";
            11:      s = "+CME ERRO";
            12:      s = "+CMS EROR: 3";
            13:      s = "+CSQ: 21,99";
            default:
            begin
                s = "";
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    s = {s, $sformatf("%c", ($urandom_range(0, 7) == 0) ?
                                      8'h20 : 8'($urandom_range(8'h21, 8'h7E)))};
            end
        endcase
        return s;
    endfunction

    task automatic add_random_burst();
        int    r;
        int    n;
        string body;
        r = $urandom_range(0, 99);
        line_cmd = 1'($urandom_range(0, 1));
        line_want = 1'($urandom_range(0, 1));
        body = line_body();
        if (r < 55)
        begin
            add_blanks($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            add_text(body);
            add_blanks($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
            add_line_end();
        end
        else if (r < 65)
        begin
            add_item(ACT_BYTE, BYTE_PROMPT);
            if ($urandom_range(0, 1))
            begin
                add_blanks($urandom_range(0, 2));
                add_line_end();
            end
        end
        else if (r < 72)
        begin
            n = $urandom_range(0, body.len());
            for (int i = 0; i < n; i++)
                add_item(ACT_BYTE, body[i]);
            if ($urandom_range(0, 3) == 0)
                add_item(ACT_BYTE, BYTE_CR);
            add_item(ACT_DROP, 8'($urandom_range(0, 255)));
        end
        else if (r < 78)
        begin
            add_blanks($urandom_range(0, 3));
            add_line_end();
        end
        else if (r < 88)
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                add_item(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
        else
        begin
            add_text(body);
            add_item(ACT_BYTE, $urandom_range(0, 1) ? BYTE_LF : BYTE_CR);
            if ($urandom_range(0, 1))
                add_item(ACT_BYTE, BYTE_PROMPT);
            add_text(line_body());
            add_line_end();
        end
    endtask

    task automatic send_item(input rx_item_t s);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= s.action;
        rx_byte <= s.rx;
        command_active <= s.cmd;
        prompt_wanted <= s.want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_and_drain();
        while (rx_queue.size() != 0)
            send_item(rx_queue.pop_front());
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle_in, input int stall_out, input logic hold);
        in_idle_pct = idle_in;
        out_stall_pct <= stall_out;
        if (hold)
            hold_go <= 1'b1;
        while (rx_queue.size() < PHASE_ITEMS)
            add_random_burst();
        send_and_drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: prompt then blank, status line, bare LF, late prompt,
        // dropped CR, drop command, interior CR, field extremes
        line_cmd = 1'b0;
        line_want = 1'b1;
        add_text("> ");
        add_crlf(0);
        line_cmd = 1'b1;
        add_text("OK");
        add_crlf(0);
        add_item(ACT_BYTE, BYTE_LF);
        add_text("A>");
        add_crlf(1);
        add_item(ACT_BYTE, 8'hFF);
        add_item(ACT_DROP, 8'hFF);
        line_want = 1'b0;
        add_text("E");
        add_item(ACT_BYTE, BYTE_CR);
        add_text("X");
        add_crlf(0);
        add_item(ACT_BYTE, 8'h00);
        add_crlf(0);
        send_and_drain();

        run_phase(0, 0, 1'b0);
        run_phase(0, 0, 1'b1);
        run_phase(46, 0, 1'b0);
        run_phase(0, 46, 1'b0);
        run_phase(21, 21, 1'b0);

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("at_response_line_classifier_top regression: pass");
        else
            $display("at_response_line_classifier_top regression: fail");
        $finish;
    end

endmodule

[files.f]
sv/atrlc_pkg.sv
sv/at_response_line_classifier_top.sv
dv/at_response_line_classifier_checker.sv
dv/at_response_line_classifier_top_tb.sv
